>>> sv/keyed_mutex_manager_macros.svh
// ----------------------------------------------------------------------------
// Keyed mutex manager assertion macros
// Concurrent assertion helpers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYED_MUTEX_MANAGER_MACROS_SVH
`define KEYED_MUTEX_MANAGER_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define KMM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define KMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define KMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define KMM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define KMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define KMM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/kmm_pkg.sv
// ----------------------------------------------------------------------------
// Keyed mutex manager package
// Sizes, field widths, request kinds and status codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmm_pkg;

    localparam int LOCK_COUNT = 16;
    localparam int TASK_COUNT = 16;

    // Fixed widths of the word fields.
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 4;
    localparam int TASK_W   = 4;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;

    // Internal widths derived from the table sizes.
    localparam int LOCK_IW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int TASK_IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int USED_W  = $clog2(LOCK_COUNT + 1);
    localparam int WCNT_W  = $clog2(TASK_COUNT + 1);
    localparam int WADDR_W = LOCK_IW + TASK_IW;

    // Request kinds.
    localparam logic [TYPE_W-1:0] REQ_OPEN    = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QFULL   = 3'd4;

    // Stream word widths.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

endpackage

`default_nettype wire

>>> sv/keyed_mutex_manager.sv
// ----------------------------------------------------------------------------
// Keyed mutex manager
// Lock table with key lookup and a FIFO wait queue for every lock.
// ----------------------------------------------------------------------------
// Usage:
// A request word enters on the s_axis channel. tuser carries the request
// kind (open, acquire, release); tdata carries the key, the lock index and
// the requesting task. Exactly one result word leaves on the m_axis channel
// for every request: a status, the index returned by an open, and on a
// release the task that was woken and now owns the lock (tuser high).
// The block works on one request at a time and holds s_axis_tready low
// until the result has been placed in the output register.
// Acquire and release pass through the execute state to the done state;
// a release that wakes a waiter adds a wake state for the waiter memory read.
// An open scans the allocated keys one at a time through a single key
// memory port and comparator, with a read state and a compare state per
// key; it ends at the first match, and when all allocated keys miss it
// goes on to the execute state to allocate a new entry (or report full).
// Reset clears the lock table count, the held flags and all queue pointers
// at once; the key and waiter memories need no clearing pass.
// When the receiver stalls, the result waits in the output register; the
// next request is still accepted and processed, and its result is held
// back until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_mutex_manager_macros.svh"

module keyed_mutex_manager
    import kmm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Request channel.
    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    // tdata: lock_key[31:0], lock_index[35:32], requester_task[39:36]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [TYPE_W-1:0]   s_axis_tuser,
    // Result channel.
    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // tdata: status[2:0], index_out[6:3], woken_task[10:7], zero fill above
    output      logic [M_DATA_W-1:0] m_axis_tdata,
    // tuser: woken_valid[0]
    output      logic                m_axis_tuser
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KREAD = 3'd1;
    localparam logic [2:0] S_KCMP  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WAKE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int CMP_W = USED_W + IDX_W;

    logic [2:0]          r_state, n_state;

    // Latched request.
    logic [TYPE_W-1:0]   r_type;
    logic [KEY_W-1:0]    r_key;
    logic [IDX_W-1:0]    r_idx;
    logic [TASK_W-1:0]   r_task;

    // Key scan counter.
    logic [LOCK_IW-1:0]  r_cnt, n_cnt;

    // Lock table state.
    logic [USED_W-1:0]   r_used;
    logic                r_held   [LOCK_COUNT];
    logic [TASK_IW-1:0]  r_head   [LOCK_COUNT];
    logic [WCNT_W-1:0]   r_wcount [LOCK_COUNT];

    // Result being built.
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_index, n_res_index;
    logic                r_res_wvalid, n_res_wvalid;
    logic [TASK_W-1:0]   r_res_wtask, n_res_wtask;

    // Output register.
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic                r_m_user;

    // Memories.
    logic                key_we;
    logic [KEY_W-1:0]    key_rdata;
    logic                wq_we;
    logic [WADDR_W-1:0]  wq_waddr;
    logic [WADDR_W-1:0]  wq_raddr;
    logic [TASK_W-1:0]   wq_rdata;

    // Table updates decided by the sequencer.
    logic                used_inc;
    logic                held_set, held_clr;
    logic                wq_push, wq_pop;

    logic                s_accept;
    logic                out_free;
    logic [LOCK_IW-1:0]  lidx;
    logic                idx_ok;
    logic [TASK_IW-1:0]  cur_head;
    logic [WCNT_W-1:0]   cur_count;
    logic [WCNT_W:0]     slot_sum;
    logic [TASK_IW-1:0]  tail_slot;
    logic [TASK_IW-1:0]  head_next;
    logic                scan_last;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign lidx     = LOCK_IW'(r_idx);
    assign idx_ok   = CMP_W'(r_idx) < CMP_W'(r_used);
    assign cur_head  = r_head[lidx];
    assign cur_count = r_wcount[lidx];

    // Tail slot of the circular queue: head plus count, wrapped once.
    assign slot_sum = (WCNT_W+1)'(cur_head) + (WCNT_W+1)'(cur_count);
    always_comb begin
        if (slot_sum >= (WCNT_W+1)'(TASK_COUNT)) begin
            tail_slot = TASK_IW'(slot_sum - (WCNT_W+1)'(TASK_COUNT));
        end else begin
            tail_slot = TASK_IW'(slot_sum);
        end
    end

    assign head_next = (cur_head == TASK_IW'(TASK_COUNT - 1)) ? '0 : cur_head + 1'b1;
    assign scan_last = (USED_W'(r_cnt) + 1'b1) >= r_used;

    assign wq_waddr = {lidx, tail_slot};
    assign wq_raddr = {lidx, cur_head};
    assign wq_we    = wq_push;

    kmm_ram #(
        .DEPTH (LOCK_COUNT),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (LOCK_IW'(r_used)),
        .i_wdata (r_key),
        .i_raddr (r_cnt),
        .o_rdata (key_rdata)
    );

    kmm_ram #(
        .DEPTH (2 ** WADDR_W),
        .WIDTH (TASK_W)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_waddr),
        .i_wdata (r_task),
        .i_raddr (wq_raddr),
        .o_rdata (wq_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_wvalid = r_res_wvalid;
        n_res_wtask  = r_res_wtask;
        key_we       = 1'b0;
        used_inc     = 1'b0;
        held_set     = 1'b0;
        held_clr     = 1'b0;
        wq_push      = 1'b0;
        wq_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_cnt        = '0;
                    n_res_status = ST_OK;
                    n_res_index  = '0;
                    n_res_wvalid = 1'b0;
                    n_res_wtask  = '0;
                    if (s_axis_tuser == REQ_OPEN && r_used != '0) begin
                        n_state = S_KREAD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_KREAD: begin
                n_state = S_KCMP;
            end
            S_KCMP: begin
                if (key_rdata == r_key) begin
                    n_res_index = IDX_W'(r_cnt);
                    n_state     = S_DONE;
                end else if (scan_last) begin
                    n_state = S_EXEC;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_KREAD;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_type)
                    REQ_OPEN: begin
                        // Reached only when the key was not found.
                        if (r_used == USED_W'(LOCK_COUNT)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            key_we      = 1'b1;
                            used_inc    = 1'b1;
                            n_res_index = IDX_W'(r_used);
                        end
                    end
                    REQ_ACQUIRE: begin
                        if (!idx_ok) begin
                            n_res_status = ST_BADIDX;
                        end else if (!r_held[lidx]) begin
                            held_set = 1'b1;
                        end else if (cur_count == WCNT_W'(TASK_COUNT)) begin
                            n_res_status = ST_QFULL;
                        end else begin
                            wq_push      = 1'b1;
                            n_res_status = ST_BLOCKED;
                        end
                    end
                    REQ_RELEASE: begin
                        if (!idx_ok) begin
                            n_res_status = ST_BADIDX;
                        end else if (cur_count == '0) begin
                            held_clr = 1'b1;
                        end else begin
                            // The waiter memory read of the head slot is under way.
                            n_state = S_WAKE;
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_WAKE: begin
                wq_pop       = 1'b1;
                n_res_wvalid = 1'b1;
                n_res_wtask  = wq_rdata;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // No word is taken while reset is held.
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_wvalid <= n_res_wvalid;
        r_res_wtask  <= n_res_wtask;
        if (s_accept) begin
            r_type <= s_axis_tuser;
            r_key  <= s_axis_tdata[KEY_W-1:0];
            r_idx  <= s_axis_tdata[KEY_W+IDX_W-1:KEY_W];
            r_task <= s_axis_tdata[KEY_W+IDX_W+TASK_W-1:KEY_W+IDX_W];
        end
    end

    // Lock table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < LOCK_COUNT; i++) begin
                r_held[i]   <= 1'b0;
                r_head[i]   <= '0;
                r_wcount[i] <= '0;
            end
        end else begin
            if (used_inc) begin
                r_used <= r_used + 1'b1;
            end
            if (held_set) begin
                r_held[lidx] <= 1'b1;
            end
            if (held_clr) begin
                r_held[lidx] <= 1'b0;
            end
            if (wq_push) begin
                r_wcount[lidx] <= cur_count + 1'b1;
            end
            if (wq_pop) begin
                r_wcount[lidx] <= cur_count - 1'b1;
                r_head[lidx]   <= head_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_m_data <= M_DATA_W'({r_res_wtask, r_res_index, r_res_status});
            r_m_user <= r_res_wvalid;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    // Assertions.
    `KMM_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_accept, !s_axis_tready, "accepted while busy")
    `KMM_ASSERT_ALWAYS(a_used, i_clk, i_rst_n, r_used <= USED_W'(LOCK_COUNT), "count overflow")
    `KMM_ASSERT_IMPL(a_held, i_clk, i_rst_n, cur_count != '0, r_held[lidx], "queue on free lock")
    `KMM_ASSERT_IMPL(a_wake, i_clk, i_rst_n, r_res_wvalid, r_res_status == ST_OK, "wake not ok")

endmodule

`default_nettype wire

>>> sv/kmm_ram.sv
// ----------------------------------------------------------------------------
// Keyed mutex manager RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> tb/sv/keyed_mutex_manager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed mutex manager testbench
// Streams open, acquire and release requests into the lock manager and checks
// every result word against a cycle-free model of the lock table and queues.
// ----------------------------------------------------------------------------

module keyed_mutex_manager_tb;
    import kmm_pkg::*;

    // The fourth request kind has no meaning; the block answers it with zeros.
    localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;
    localparam int RANDOM_WORDS = 1500;
    // Leave slack after the last word, enough for the longest open scan.
    localparam int SETTLE_CYCLES = 2 * LOCK_COUNT + 20;

    typedef struct {
        logic [TYPE_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  idx;
        logic [TASK_W-1:0] requester;
        bit                drain;     // hold this word back until all answers are in
    } lock_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic                woken;
        logic [TASK_W-1:0]   woken_task;
    } lock_answer_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // tdata: lock_key[31:0], lock_index[35:32], requester_task[39:36]
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    // tuser: req_type[1:0]
    logic [TYPE_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tdata: status[2:0], index_out[6:3], woken_task[10:7], zero fill above
    logic [M_DATA_W-1:0] m_axis_tdata;
    // tuser: woken_valid[0]
    logic                m_axis_tuser;

    keyed_mutex_manager dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    lock_request_t request_q[$];   // words not yet offered to the block
    lock_answer_t  answer_q[$];    // answers owed by the block, oldest first
    lock_request_t bus_request;    // word currently offered on the request bus
    logic [KEY_W-1:0] key_pool[$]; // distinct keys opened so far, in table order
    bit  request_taken = 1'b0;
    int  mismatches = 0;
    int  counted_words = 0;
    int  planned_words = 0;
    int  offered_words = 0;
    int  tx_idle_pct = 13;
    int  rx_idle_pct = 50;

    // Model of the lock table and the per-lock wait rings.
    logic [KEY_W-1:0]  key_table[LOCK_COUNT];
    bit                lock_busy[LOCK_COUNT];
    int                open_locks = 0;
    logic [TASK_W-1:0] wait_ring[LOCK_COUNT][TASK_COUNT];
    int                wait_head[LOCK_COUNT];
    int                wait_len[LOCK_COUNT];

    initial begin
        for (int i = 0; i < LOCK_COUNT; i++) begin
            lock_busy[i] = 1'b0;
            wait_head[i] = 0;
            wait_len[i] = 0;
        end
    end

    // Applies one request to the lock table model and returns its answer.
    function automatic lock_answer_t apply_lock_request(input lock_request_t req);
        lock_answer_t ans;
        bit found;
        int slot;
        ans = '{ST_OK, '0, 1'b0, '0};
        found = 1'b0;
        case (req.kind)
            REQ_OPEN: begin
                for (int i = 0; i < open_locks; i++) begin
                    if (!found && key_table[i] == req.key) begin
                        ans.index = i[IDX_W-1:0];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (open_locks >= LOCK_COUNT) begin
                        ans.status = ST_FULL;
                    end else begin
                        key_table[open_locks] = req.key;
                        ans.index = open_locks[IDX_W-1:0];
                        open_locks++;
                    end
                end
            end
            REQ_ACQUIRE, REQ_RELEASE: begin
                if (int'(req.idx) >= open_locks) begin
                    ans.status = ST_BADIDX;
                end else if (req.kind == REQ_ACQUIRE) begin
                    if (!lock_busy[req.idx]) begin
                        lock_busy[req.idx] = 1'b1;
                    end else if (wait_len[req.idx] >= TASK_COUNT) begin
                        ans.status = ST_QFULL;
                    end else begin
                        slot = (wait_head[req.idx] + wait_len[req.idx]) % TASK_COUNT;
                        wait_ring[req.idx][slot] = req.requester;
                        wait_len[req.idx]++;
                        ans.status = ST_BLOCKED;
                    end
                end else begin
                    // A release with waiters hands the lock over; it stays held.
                    if (wait_len[req.idx] == 0) begin
                        lock_busy[req.idx] = 1'b0;
                    end else begin
                        ans.woken = 1'b1;
                        ans.woken_task = wait_ring[req.idx][wait_head[req.idx]];
                        wait_head[req.idx] = (wait_head[req.idx] + 1) % TASK_COUNT;
                        wait_len[req.idx]--;
                    end
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic queue_request(input logic [TYPE_W-1:0] kind, input logic [KEY_W-1:0] key,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [TASK_W-1:0] requester, input bit drain);
        bit known;
        known = 1'b0;
        if (kind == REQ_OPEN) begin
            foreach (key_pool[i]) begin
                if (key_pool[i] == key) begin
                    known = 1'b1;
                end
            end
            if (!known && key_pool.size() < LOCK_COUNT) begin
                key_pool.push_back(key);
            end
        end
        if (kind != REQ_NONE) begin
            counted_words++;
        end
        request_q.push_back('{kind, key, idx, requester, drain});
    endtask

    // Monitor: result words are checked before the word accepted at the same
    // edge is modeled, since a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        lock_answer_t got;
        lock_answer_t want;
        request_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[2:0];
            got.index = m_axis_tdata[6:3];
            got.woken_task = m_axis_tdata[10:7];
            got.woken = m_axis_tuser;
            if (answer_q.size() == 0) begin
                report_mismatch("result word with no request pending", int'(got.status), -1);
            end else begin
                want = answer_q.pop_front();
                if (got.status !== want.status) begin
                    report_mismatch("status", int'(got.status), int'(want.status));
                end
                if (got.index !== want.index) begin
                    report_mismatch("index_out", int'(got.index), int'(want.index));
                end
                if (got.woken !== want.woken) begin
                    report_mismatch("woken_valid", int'(got.woken), int'(want.woken));
                end
                if (got.woken_task !== want.woken_task) begin
                    report_mismatch("woken_task", int'(got.woken_task),
                                    int'(want.woken_task));
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            answer_q.push_back(apply_lock_request(bus_request));
        end
    end

    // Driver: a word stays on the bus until it is taken; a new one or a gap
    // follows only after that.
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
        if (i_rst_n && (!s_axis_tvalid || request_taken)) begin
            if (request_q.size() == 0 || $urandom_range(0, 99) < tx_idle_pct ||
                    (request_q[0].drain && answer_q.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                bus_request <= request_q[0];
                s_axis_tdata <= {request_q[0].requester, request_q[0].idx, request_q[0].key};
                s_axis_tuser <= request_q[0].kind;
                s_axis_tvalid <= 1'b1;
                void'(request_q.pop_front());
                offered_words++;
                if (offered_words >= 2 * planned_words / 3) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end else if (offered_words >= planned_words / 3) begin
                    tx_idle_pct = 50;
                    rx_idle_pct = 13;
                end
            end
        end
    end

    initial begin
        int pick;
        int lock_sel;
        int acquires;
        int releases;
        bit drain;
        logic [KEY_W-1:0] key;

        // Directed part: unopened locks, the ignored kind, key extremes, a
        // repeated key, release of a free lock, duplicate waiters and hand-over.
        queue_request(REQ_ACQUIRE, 32'h0, 4'd0, 4'd0, 1'b0);
        queue_request(REQ_RELEASE, 32'hFFFF_FFFF, 4'd15, 4'd15, 1'b0);
        queue_request(REQ_NONE, 32'hA5A5_5A5A, 4'd9, 4'd6, 1'b0);
        queue_request(REQ_OPEN, 32'h0000_0000, 4'd0, 4'd0, 1'b0);
        queue_request(REQ_OPEN, 32'hFFFF_FFFF, 4'd15, 4'd15, 1'b0);
        queue_request(REQ_OPEN, 32'h8000_0000, 4'd0, 4'd0, 1'b0);
        queue_request(REQ_OPEN, 32'h7FFF_FFFF, 4'd15, 4'd15, 1'b0);
        queue_request(REQ_OPEN, 32'hFFFF_FFFF, 4'd0, 4'd0, 1'b0);
        queue_request(REQ_RELEASE, 32'h0, 4'd2, 4'd0, 1'b0);
        queue_request(REQ_ACQUIRE, 32'h0, 4'd3, 4'd15, 1'b0);
        queue_request(REQ_ACQUIRE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_ACQUIRE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_ACQUIRE, 32'h0, 4'd3, 4'd9, 1'b0);
        queue_request(REQ_RELEASE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_RELEASE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_RELEASE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_RELEASE, 32'h0, 4'd3, 4'd0, 1'b0);
        queue_request(REQ_ACQUIRE, 32'h0, 4'd4, 4'd1, 1'b0);

        // Random part: mostly acquire bursts followed by matching releases on
        // opened locks, mixed with opens and malformed or ignored requests.
        // Long bursts run the wait queues into overflow, fresh keys fill the
        // table.
        drain = 1'b1;
        counted_words = 0;
        while (counted_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0) begin
                drain = 1'b1;
            end
            if (pick < 12) begin
                if (key_pool.size() != 0 &&
                        $urandom_range(0, 99) < (key_pool.size() < LOCK_COUNT ? 40 : 75)) begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end else begin
                    key = $urandom;
                end
                queue_request(REQ_OPEN, key, IDX_W'($urandom_range(0, 15)),
                              TASK_W'($urandom_range(0, 15)), drain);
                drain = 1'b0;
            end else if (pick < 20) begin
                queue_request(TYPE_W'($urandom_range(1, 3)), $urandom,
                              IDX_W'($urandom_range(0, 15)),
                              TASK_W'($urandom_range(0, 15)), drain);
                drain = 1'b0;
            end else begin
                if (key_pool.size() != 0 && $urandom_range(0, 9) != 0) begin
                    lock_sel = $urandom_range(0, key_pool.size() - 1);
                end else begin
                    lock_sel = $urandom_range(0, LOCK_COUNT - 1);
                end
                acquires = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                       : $urandom_range(1, 6);
                releases = acquires + $urandom_range(0, 2) - 1;
                for (int i = 0; i < acquires; i++) begin
                    queue_request(REQ_ACQUIRE, $urandom, IDX_W'(lock_sel),
                                  TASK_W'($urandom_range(0, 15)), drain);
                    drain = 1'b0;
                end
                for (int i = 0; i < releases; i++) begin
                    queue_request(REQ_RELEASE, $urandom, IDX_W'(lock_sel),
                                  TASK_W'($urandom_range(0, 15)), 1'b0);
                end
            end
        end
        planned_words = request_q.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the whole stimulus.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
